FILE: rtl/core/nmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmt_pkg
// Shared types, constants and the distance function of the nearest match unit.
// ----------------------------------------------------------------------------
package nmt_pkg;

  // field widths
  localparam int ATTR_W    = 4;
  localparam int NUM_ATTRS = 7;
  localparam int ENTRY_W   = ATTR_W * NUM_ATTRS;
  localparam int IDX_W     = 5;
  localparam int DIST_W    = 7;
  localparam int TIE_W     = 6;
  localparam int CFG_W     = 6;
  // width that holds any table index or table size in range
  localparam int IDX_EXT_W = 9;

  // defaults and limits
  localparam int              DEF_TABLE_ENTRIES = 32;
  localparam int              MAX_SEARCH        = 32;
  localparam logic [CFG_W-1:0] CFG_RESET        = 6'd30;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // decoded item held in the queue
  typedef struct packed {
    logic                 is_query;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic [ENTRY_W-1:0]   attrs;
  } nmt_cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } nmt_state_t;

  // sum of absolute attribute differences
  function automatic logic [DIST_W-1:0] nmt_distance(
    input logic [ENTRY_W-1:0] entry,
    input logic [ENTRY_W-1:0] qry
  );
    logic [ATTR_W-1:0] e;
    logic [ATTR_W-1:0] q;
    logic [ATTR_W-1:0] d;
    logic [DIST_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < NUM_ATTRS; k++) begin
      e = entry[ATTR_W*k +: ATTR_W];
      q = qry[ATTR_W*k +: ATTR_W];
      d = (e >= q) ? (e - q) : (q - e);
      sum = sum + {{(DIST_W-ATTR_W){1'b0}}, d};
    end
    return sum;
  endfunction

endpackage

FILE: rtl/core/nmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nmt_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/core/nmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmt_front
// Accepts items, decodes operation and index range, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nmt_front
  import nmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [ATTR_W-1:0]  in_attr_logic,
  input  logic [ATTR_W-1:0]  in_attr_charisma,
  input  logic [ATTR_W-1:0]  in_attr_strength,
  input  logic [ATTR_W-1:0]  in_attr_agility,
  input  logic [ATTR_W-1:0]  in_attr_mystic,
  input  logic [ATTR_W-1:0]  in_attr_legitimacy,
  input  logic [ATTR_W-1:0]  in_attr_resistance,
  output logic               q_valid,
  output nmt_cmd_t           q_cmd,
  input  logic               q_pop
);

  nmt_cmd_t   q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  nmt_cmd_t   dec;
  logic       push;

  // decode of the incoming item
  always_comb begin
    dec.is_query = (in_operation == OP_QUERY);
    dec.in_range = ({{(IDX_EXT_W-IDX_W){1'b0}}, in_entry_index}
                    < IDX_EXT_W'(TABLE_ENTRIES));
    dec.idx      = in_entry_index;
    dec.attrs    = {in_attr_resistance, in_attr_legitimacy, in_attr_mystic,
                    in_attr_agility, in_attr_strength, in_attr_charisma,
                    in_attr_logic};
  end

  // queue flags and pointers
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: rtl/core/nmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmt_back
// Carries out queued items: writes table entries, or walks the table with one
// distance unit, tracks the least distance and tie mask, then emits the ties.
// ----------------------------------------------------------------------------
module nmt_back
  import nmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   entries_in_use,
  input  logic               q_valid,
  input  nmt_cmd_t           q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_match_index,
  output logic [DIST_W-1:0]  out_least_dist,
  output logic [TIE_W-1:0]   out_tie_count,
  output logic               out_exact_match,
  output logic               out_is_query_result,
  output logic               out_is_last
);

  localparam int SEARCH_MAX = (TABLE_ENTRIES < MAX_SEARCH) ? TABLE_ENTRIES : MAX_SEARCH;
  localparam int MASK_W     = SEARCH_MAX;
  localparam int MIDX_W     = (MASK_W > 1) ? $clog2(MASK_W) : 1;
  localparam int AW         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  nmt_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    scan_r;
  logic                rd_pend_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [ENTRY_W-1:0]  qry_r;
  logic [CFG_W-1:0]    n_r;
  logic [DIST_W-1:0]   best_r;
  logic [MASK_W-1:0]   mask_r;
  logic [TIE_W-1:0]    count_r;
  logic [TIE_W-1:0]    sent_r;

  logic                out_valid_r;
  logic [IDX_W-1:0]    match_index_r;
  logic [DIST_W-1:0]   least_dist_r;
  logic [TIE_W-1:0]    tie_count_r;
  logic                exact_match_r;
  logic                is_query_r;
  logic                is_last_r;

  logic                slot_free;
  logic                scan_last;
  logic                emit_last;
  logic [CFG_W-1:0]    n_eff;
  logic                start;
  logic                rd_issue;
  logic                ram_we;
  logic                load_ack;
  logic                load_res;
  logic [ENTRY_W-1:0]  rdata;
  logic [DIST_W-1:0]   ent_dist;
  logic [MASK_W-1:0]   hit_bit;
  logic [IDX_W-1:0]    ffs_idx;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [IDX_EXT_W-1:0] widx_ext;
  logic [IDX_EXT_W-1:0] ridx_ext;

  // prototype table
  assign widx_ext = {{(IDX_EXT_W-IDX_W){1'b0}}, q_cmd.idx};
  assign ridx_ext = {{(IDX_EXT_W-IDX_W){1'b0}}, scan_r};
  assign waddr    = widx_ext[AW-1:0];
  assign raddr    = ridx_ext[AW-1:0];

  nmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (q_cmd.attrs),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // effective search count from the register
  always_comb begin
    priority if (entries_in_use == '0) begin
      n_eff = CFG_W'(1);
    end else if (entries_in_use > CFG_W'(SEARCH_MAX)) begin
      n_eff = CFG_W'(SEARCH_MAX);
    end else begin
      n_eff = entries_in_use;
    end
  end

  // status terms
  assign slot_free = !out_valid_r || !out_stall;
  assign scan_last = ({1'b0, scan_r} == (n_r - CFG_W'(1)));
  assign emit_last = ((sent_r + TIE_W'(1)) == count_r);
  assign ent_dist  = nmt_distance(rdata, qry_r);
  assign hit_bit   = MASK_W'(1) << rd_idx_r[MIDX_W-1:0];

  // lowest tied entry still to send
  always_comb begin
    ffs_idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        ffs_idx = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_cmd.is_query) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    start    = 1'b0;
    rd_issue = 1'b0;
    ram_we   = 1'b0;
    load_ack = 1'b0;
    load_res = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_cmd.is_query) begin
          q_pop = 1'b1;
          start = 1'b1;
        end else if (q_valid && slot_free) begin
          q_pop    = 1'b1;
          ram_we   = q_cmd.in_range;
          load_ack = 1'b1;
        end
      end
      ST_SCAN: begin
        rd_issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        load_res = slot_free;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_issue;
      if (load_ack || load_res) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan and least distance tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r  <= '0;
      mask_r  <= '0;
      count_r <= '0;
    end else if (start) begin
      best_r  <= '1;
      mask_r  <= '0;
      count_r <= '0;
    end else if (rd_pend_r) begin
      if (ent_dist < best_r) begin
        best_r  <= ent_dist;
        mask_r  <= hit_bit;
        count_r <= TIE_W'(1);
      end else if (ent_dist == best_r) begin
        mask_r  <= mask_r | hit_bit;
        count_r <= count_r + TIE_W'(1);
      end
    end else if (load_res) begin
      mask_r <= mask_r & ~(MASK_W'(1) << ffs_idx[MIDX_W-1:0]);
    end
  end

  // query context and read pipeline
  always_ff @(posedge clk) begin
    if (start) begin
      qry_r  <= q_cmd.attrs;
      n_r    <= n_eff;
      scan_r <= '0;
      sent_r <= '0;
    end else begin
      if (rd_issue) begin
        scan_r <= scan_r + IDX_W'(1);
      end
      if (load_res) begin
        sent_r <= sent_r + TIE_W'(1);
      end
    end
    rd_idx_r <= scan_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_ack) begin
      match_index_r <= q_cmd.idx;
      least_dist_r  <= '0;
      tie_count_r   <= '0;
      exact_match_r <= 1'b0;
      is_query_r    <= 1'b0;
      is_last_r     <= 1'b1;
    end else if (load_res) begin
      match_index_r <= ffs_idx;
      least_dist_r  <= best_r;
      tie_count_r   <= count_r;
      exact_match_r <= (best_r == '0);
      is_query_r    <= 1'b1;
      is_last_r     <= emit_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_match_index     = match_index_r;
  assign out_least_dist      = least_dist_r;
  assign out_tie_count       = tie_count_r;
  assign out_exact_match     = exact_match_r;
  assign out_is_query_result = is_query_r;
  assign out_is_last         = is_last_r;

endmodule

FILE: rtl/core/manhattan_nearest_match_with_ties_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manhattan_nearest_match_with_ties_unit
// Nearest prototype search by sum of absolute differences, with tie results.
// ----------------------------------------------------------------------------
//  port group | handshake          | payload
//  in_        | in_valid/in_stall  | operation, entry_index, seven attributes
//  out_       | out_valid/out_stall| match_index, least_dist, tie_count, flags
//  cfg_       | cfg_wr_en          | cfg_wr_data (entries in use)
//
// a write item gives one acknowledgment once the output register is free.
// a query walks N entries through the single distance unit (one table read
// per cycle, registered read), then gives one result per tied entry on the
// output. the two-entry queue takes items while the back end is busy, until
// it is full. rst_n is synchronous; the table holds no reset value and must
// be written first by the user: the block itself does not enforce this.
// ----------------------------------------------------------------------------
module manhattan_nearest_match_with_ties_unit
  import nmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [ATTR_W-1:0]  in_attr_logic,
  input  logic [ATTR_W-1:0]  in_attr_charisma,
  input  logic [ATTR_W-1:0]  in_attr_strength,
  input  logic [ATTR_W-1:0]  in_attr_agility,
  input  logic [ATTR_W-1:0]  in_attr_mystic,
  input  logic [ATTR_W-1:0]  in_attr_legitimacy,
  input  logic [ATTR_W-1:0]  in_attr_resistance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_match_index,
  output logic [DIST_W-1:0]  out_least_dist,
  output logic [TIE_W-1:0]   out_tie_count,
  output logic               out_exact_match,
  output logic               out_is_query_result,
  output logic               out_is_last
);

  logic [CFG_W-1:0] entries_in_use_r;
  logic             q_valid;
  nmt_cmd_t         q_cmd;
  logic             q_pop;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      entries_in_use_r <= cfg_wr_data;
    end
  end

  // accept and queue
  nmt_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_entry_index     (in_entry_index),
    .in_attr_logic      (in_attr_logic),
    .in_attr_charisma   (in_attr_charisma),
    .in_attr_strength   (in_attr_strength),
    .in_attr_agility    (in_attr_agility),
    .in_attr_mystic     (in_attr_mystic),
    .in_attr_legitimacy (in_attr_legitimacy),
    .in_attr_resistance (in_attr_resistance),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop)
  );

  // table, search and result emission
  nmt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .entries_in_use      (entries_in_use_r),
    .q_valid             (q_valid),
    .q_cmd               (q_cmd),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_match_index     (out_match_index),
    .out_least_dist      (out_least_dist),
    .out_tie_count       (out_tie_count),
    .out_exact_match     (out_exact_match),
    .out_is_query_result (out_is_query_result),
    .out_is_last         (out_is_last)
  );

  // exact match only with zero distance
  a_exact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exact_match |-> out_least_dist == '0)
    else $error("exact match with nonzero distance");

  // a query result always reports at least one tie
  a_query_ties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_query_result |-> out_tie_count != '0)
    else $error("query result with zero tie count");

  // a write acknowledgment is single and carries no tie count
  a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_query_result |-> out_is_last && out_tie_count == '0)
    else $error("malformed write acknowledgment");

  // the queue never pops when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

FILE: dv/tb_manhattan_nearest_match_with_ties_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_manhattan_nearest_match_with_ties_unit
// Self-checking bench for the nearest match unit. Table writes and queries
// are fed from a queue by a clocked driver with random idle cycles, and the
// result side is stalled at random. Every accepted item is run through a
// local model of the distance search, and each result is compared field by
// field with the oldest expected result. The entry count register is changed
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_manhattan_nearest_match_with_ties_unit;
  import nmt_pkg::*;

  localparam int TB_ENTRIES    = DEF_TABLE_ENTRIES;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_PCT      = 22;
  localparam int WRITE_PCT     = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 60;
  localparam int CALM_FROM     = 3000;
  localparam int CALM_TO       = 8000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 40;

  typedef logic [NUM_ATTRS-1:0][ATTR_W-1:0] attr_vec_t;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    attr_vec_t        attrs;
  } match_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] least_dist;
    logic [TIE_W-1:0]  tie_count;
    logic              exact_match;
    logic              is_query_result;
    logic              is_last;
  } match_result_t;

  // how attribute vectors are drawn
  typedef enum int {
    VEC_FULL,
    VEC_RAIL,
    VEC_NARROW
  } vec_flavour_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = OP_WRITE;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [ATTR_W-1:0] in_attr_logic = '0;
  logic [ATTR_W-1:0] in_attr_charisma = '0;
  logic [ATTR_W-1:0] in_attr_strength = '0;
  logic [ATTR_W-1:0] in_attr_agility = '0;
  logic [ATTR_W-1:0] in_attr_mystic = '0;
  logic [ATTR_W-1:0] in_attr_legitimacy = '0;
  logic [ATTR_W-1:0] in_attr_resistance = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_match_index;
  logic [DIST_W-1:0] out_least_dist;
  logic [TIE_W-1:0]  out_tie_count;
  logic              out_exact_match;
  logic              out_is_query_result;
  logic              out_is_last;

  match_item_t   pending_items[$];
  match_result_t expected_matches[$];
  match_item_t   cur_item;
  match_item_t   seen_item;
  match_result_t seen_result;

  // model state
  attr_vec_t        proto_tab [TB_ENTRIES];
  logic [CFG_W-1:0] span_cfg = CFG_RESET;

  // stimulus bookkeeping, in generation order
  bit        gen_written [TB_ENTRIES];
  attr_vec_t gen_shadow [TB_ENTRIES];

  int items_sent  = 0;
  int items_taken = 0;
  int fail_cnt    = 0;
  int cycle_cnt   = 0;
  bit in_took     = 1'b0;
  wire calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  manhattan_nearest_match_with_ties_unit #(
    .TABLE_ENTRIES(TB_ENTRIES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_entry_index     (in_entry_index),
    .in_attr_logic      (in_attr_logic),
    .in_attr_charisma   (in_attr_charisma),
    .in_attr_strength   (in_attr_strength),
    .in_attr_agility    (in_attr_agility),
    .in_attr_mystic     (in_attr_mystic),
    .in_attr_legitimacy (in_attr_legitimacy),
    .in_attr_resistance (in_attr_resistance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_match_index    (out_match_index),
    .out_least_dist     (out_least_dist),
    .out_tie_count      (out_tie_count),
    .out_exact_match    (out_exact_match),
    .out_is_query_result(out_is_query_result),
    .out_is_last        (out_is_last)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // entries searched for a given register value
  function automatic int search_span(input logic [CFG_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    if (n > TB_ENTRIES) n = TB_ENTRIES;
    if (n > MAX_SEARCH) n = MAX_SEARCH;
    return n;
  endfunction

  function automatic int attr_gap_sum(input attr_vec_t a, input attr_vec_t b);
    int sum;
    int gap;
    sum = 0;
    for (int k = 0; k < NUM_ATTRS; k++) begin
      gap = int'(a[k]) - int'(b[k]);
      sum += (gap < 0) ? -gap : gap;
    end
    return sum;
  endfunction

  // expected results of one accepted item
  task automatic predict_match(input match_item_t it);
    int            gap_tab [TB_ENTRIES];
    int            span;
    int            best;
    int            ties;
    int            seen;
    match_result_t r;
    r = '0;
    if (it.op == OP_WRITE) begin
      if (it.idx < TB_ENTRIES) proto_tab[it.idx] = it.attrs;
      r.match_index = it.idx;
      r.is_last     = 1'b1;
      expected_matches.push_back(r);
    end else begin
      span = search_span(span_cfg);
      best = 127;
      ties = 0;
      seen = 0;
      for (int i = 0; i < span; i++) begin
        gap_tab[i] = attr_gap_sum(proto_tab[i], it.attrs);
        if (gap_tab[i] < best) best = gap_tab[i];
      end
      for (int i = 0; i < span; i++) begin
        if (gap_tab[i] == best) ties++;
      end
      // one result per tied entry, lowest index first
      for (int i = 0; i < span; i++) begin
        if (gap_tab[i] == best) begin
          seen++;
          r.match_index     = IDX_W'(i);
          r.least_dist      = DIST_W'(best);
          r.tie_count       = TIE_W'(ties);
          r.exact_match     = (best == 0);
          r.is_query_result = 1'b1;
          r.is_last         = (seen == ties);
          expected_matches.push_back(r);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result(input match_result_t act);
    match_result_t want;
    if (expected_matches.size() == 0) begin
      $error("result with nothing expected, match_index %0d", act.match_index);
      fail_cnt++;
    end else begin
      want = expected_matches.pop_front();
      check_field("match_index", 32'(want.match_index), 32'(act.match_index));
      check_field("least_dist", 32'(want.least_dist), 32'(act.least_dist));
      check_field("tie_count", 32'(want.tie_count), 32'(act.tie_count));
      check_field("exact_match", 32'(want.exact_match), 32'(act.exact_match));
      check_field("is_query_result", 32'(want.is_query_result),
                  32'(act.is_query_result));
      check_field("is_last", 32'(want.is_last), 32'(act.is_last));
    end
  endtask

  // input driver: next item goes out once the current one is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item           = pending_items.pop_front();
          in_valid           <= 1'b1;
          in_operation       <= cur_item.op;
          in_entry_index     <= cur_item.idx;
          in_attr_logic      <= cur_item.attrs[0];
          in_attr_charisma   <= cur_item.attrs[1];
          in_attr_strength   <= cur_item.attrs[2];
          in_attr_agility    <= cur_item.attrs[3];
          in_attr_mystic     <= cur_item.attrs[4];
          in_attr_legitimacy <= cur_item.attrs[5];
          in_attr_resistance <= cur_item.attrs[6];
        end else begin
          in_valid <= 1'b0;
        end
      end
      // result side back-pressure
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: results are checked before the item of this edge is predicted
  always @(posedge clk) begin
    cycle_cnt++;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_result.match_index     = out_match_index;
        seen_result.least_dist      = out_least_dist;
        seen_result.tie_count       = out_tie_count;
        seen_result.exact_match     = out_exact_match;
        seen_result.is_query_result = out_is_query_result;
        seen_result.is_last         = out_is_last;
        check_result(seen_result);
      end
      if (in_valid && !in_stall) begin
        in_took        = 1'b1;
        items_taken++;
        seen_item.op    = in_operation;
        seen_item.idx   = in_entry_index;
        seen_item.attrs = {in_attr_resistance, in_attr_legitimacy, in_attr_mystic,
                           in_attr_agility, in_attr_strength, in_attr_charisma,
                           in_attr_logic};
        predict_match(seen_item);
      end
    end
  end

  function automatic attr_vec_t flat_vec(input logic [ATTR_W-1:0] v);
    return {NUM_ATTRS{v}};
  endfunction

  function automatic attr_vec_t rand_vec(input vec_flavour_t flavour);
    attr_vec_t v;
    for (int k = 0; k < NUM_ATTRS; k++) begin
      case (flavour)
        VEC_FULL: v[k] = ATTR_W'($urandom_range(15));
        VEC_RAIL: v[k] = $urandom_range(1) ? 4'hF : 4'h0;
        default:  v[k] = ATTR_W'($urandom_range(2));
      endcase
    end
    return v;
  endfunction

  // query vectors, some copied from a searched entry for an exact hit
  function automatic attr_vec_t query_vec(input int span);
    if ($urandom_range(3) == 0) return gen_shadow[$urandom_range(span - 1)];
    return rand_vec(vec_flavour_t'($urandom_range(2)));
  endfunction

  task automatic queue_item(input logic op, input int idx, input attr_vec_t v);
    match_item_t it;
    it.op    = op;
    it.idx   = IDX_W'(idx);
    it.attrs = v;
    pending_items.push_back(it);
    items_sent++;
    if (op == OP_WRITE && idx < TB_ENTRIES) begin
      gen_written[idx] = 1'b1;
      gen_shadow[idx]  = v;
    end
  endtask

  task automatic wait_idle();
    while (items_taken != items_sent || expected_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_entries_in_use(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    span_cfg = v;
  endtask

  // one random phase at a given entry count
  task automatic run_phase(input logic [CFG_W-1:0] cfg_val, input int count);
    int span;
    write_entries_in_use(cfg_val);
    span = search_span(cfg_val);
    // every searched entry holds a value before the first query
    for (int i = 0; i < span; i++) begin
      if (!gen_written[i]) queue_item(OP_WRITE, i, rand_vec(vec_flavour_t'($urandom_range(2))));
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < WRITE_PCT)
        queue_item(OP_WRITE, $urandom_range(TB_ENTRIES - 1),
                   rand_vec(vec_flavour_t'($urandom_range(2))));
      else
        queue_item(OP_QUERY, $urandom_range(31), query_vec(span));
    end
  endtask

  // cycle limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero count searches entry 0 alone
    write_entries_in_use(6'd0);
    queue_item(OP_WRITE, 0, flat_vec(4'h0));
    queue_item(OP_QUERY, 31, flat_vec(4'h0));
    queue_item(OP_QUERY, 0, flat_vec(4'hF));
    queue_item(OP_WRITE, 31, flat_vec(4'hF));
    queue_item(OP_WRITE, 0, flat_vec(4'hF));
    queue_item(OP_WRITE, 1, flat_vec(4'hF));
    queue_item(OP_WRITE, 2, flat_vec(4'h0));
    queue_item(OP_WRITE, 3, flat_vec(4'hF));
    queue_item(OP_QUERY, 21, attr_vec_t'(28'h5A5A5A5));

    // four entries: exact three-way tie, single hit, inexact tie
    write_entries_in_use(6'd4);
    queue_item(OP_QUERY, 0, flat_vec(4'hF));
    queue_item(OP_QUERY, 10, flat_vec(4'h0));
    queue_item(OP_QUERY, 0, flat_vec(4'h8));
    queue_item(OP_QUERY, 31, attr_vec_t'(28'hF0F0F0F));
    queue_item(OP_WRITE, 3, attr_vec_t'(28'h0F0F0F0));
    queue_item(OP_QUERY, 5, attr_vec_t'(28'h0F0F0F0));

    write_entries_in_use(6'd1);
    queue_item(OP_QUERY, 16, attr_vec_t'(28'h1234567));

    // random phases, saturating counts and extremes included
    run_phase(6'd32, PHASE_ITEMS);
    run_phase(6'd63, PHASE_ITEMS);
    run_phase(6'd1, PHASE_ITEMS);
    run_phase(6'd0, PHASE_ITEMS);
    run_phase(6'd30, PHASE_ITEMS);
    run_phase(CFG_W'($urandom_range(63)), PHASE_ITEMS);
    run_phase(6'd2, PHASE_ITEMS);
    run_phase(CFG_W'($urandom_range(63)), PHASE_ITEMS);
    run_phase(6'd32, PHASE_ITEMS);
    run_phase(6'd17, PHASE_ITEMS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && expected_matches.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/nmt_pkg.sv
rtl/core/nmt_ram.sv
rtl/core/nmt_front.sv
rtl/core/nmt_back.sv
rtl/core/manhattan_nearest_match_with_ties_unit.sv
dv/tb_manhattan_nearest_match_with_ties_unit.sv
